// ===== hdl/usad_pkg.sv =====
`default_nettype none

package usad_pkg;

   localparam int IW       = 8;
   localparam int GRID_MAX = 2 ** IW;
   localparam int DW       = 32;
   localparam int CW       = 16;
   localparam int CSR_IW   = 3;

   localparam logic [CSR_IW-1:0] CSR_GRID_LAST   = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_ADV_X_COEF  = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_ADV_Y_COEF  = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_DIFF_X_COEF = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_DIFF_Y_COEF = 3'd4;

   typedef struct packed {
      logic [IW-1:0] grid_last;
      logic [CW-1:0] adv_x;
      logic [CW-1:0] adv_y;
      logic [CW-1:0] diff_x;
      logic [CW-1:0] diff_y;
   } usad_cfg_type;

   typedef struct packed {
      logic                 acc;
      logic                 emit;
      logic                 last;
      logic [IW-1:0]        row;
      logic [IW-1:0]        col;
      logic signed [DW-1:0] s_rho;
      logic signed [DW-1:0] n;
      logic signed [DW-1:0] ctr;
      logic signed [DW-1:0] e;
      logic signed [DW-1:0] uu;
      logic signed [DW-1:0] vv;
   } usad_win_type;

   typedef struct packed {
      logic [IW-1:0] row;
      logic [IW-1:0] col;
      logic          last;
   } usad_tag_type;

   typedef struct packed {
      logic signed [DW-1:0] rho;
      logic [IW-1:0]        row;
      logic [IW-1:0]        col;
      logic                 last;
   } usad_res_type;

endpackage

`default_nettype wire

// ===== hdl/upwind_scalar_advect_diffuse.sv =====
`default_nettype none
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | tdata: rho_sample, u_vel, v_vel; tuser: frame_start
// rsp     | out | rsp_tvalid/rsp_tready | tdata: rho_new, row_index, col_index; tlast: last_of_frame
// csr     | in  | csr_valid/csr_ready   | csr_index, csr_data
//
// One word per cycle while the skid is empty; results pass line regs, stages 2-7 and out_ff.
// The rate is set by the density line banks, each read at two columns per cycle.
// Reset clears the row/column counters, pipeline valids and the registers to their
// defaults; line buffers are not cleared.
// A result behind a stalled rsp word parks in a one-entry skid; req stalls only when it is full.

module upwind_scalar_advect_diffuse (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [95:0]                    req_tdata,   // rho_sample, u_vel, v_vel
   input  logic                           req_tuser,   // frame_start
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [47:0]                    rsp_tdata,   // rho_new, row_index, col_index
   output logic                           rsp_tlast,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [usad_pkg::CSR_IW-1:0]    csr_index,
   input  logic [usad_pkg::CW-1:0]        csr_data
);
   import usad_pkg::*;

   usad_cfg_type cfg_ff;
   usad_win_type win;
   usad_res_type res, out_ff, sk_ff;
   logic         res_valid, out_valid_ff, sk_valid_ff;
   logic         en, acc, take;

   assign en         = !sk_valid_ff;
   assign req_tready = en;
   assign acc        = req_tvalid && en;
   assign take       = out_valid_ff && rsp_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_last <= IW'(100);
         cfg_ff.adv_x     <= '0;
         cfg_ff.adv_y     <= '0;
         cfg_ff.diff_x    <= '0;
         cfg_ff.diff_y    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GRID_LAST:   cfg_ff.grid_last <= csr_data[IW-1:0];
            CSR_ADV_X_COEF:  cfg_ff.adv_x     <= csr_data;
            CSR_ADV_Y_COEF:  cfg_ff.adv_y     <= csr_data;
            CSR_DIFF_X_COEF: cfg_ff.diff_x    <= csr_data;
            CSR_DIFF_Y_COEF: cfg_ff.diff_y    <= csr_data;
            default: ;
         endcase
      end
   end

   usad_lines u_lines (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .acc         (acc),
      .frame_start (req_tuser),
      .rho_in      (req_tdata[31:0]),
      .u_in        (req_tdata[63:32]),
      .v_in        (req_tdata[95:64]),
      .grid_last   (cfg_ff.grid_last),
      .win         (win)
   );

   usad_calc u_calc (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .win       (win),
      .res       (res),
      .res_valid (res_valid)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sk_valid_ff  <= 1'b0;
      end else if (sk_valid_ff) begin
         if (take) begin
            out_ff      <= sk_ff;
            sk_valid_ff <= 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || take) begin
            out_ff       <= res;
            out_valid_ff <= 1'b1;
         end else begin
            sk_ff       <= res;
            sk_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.col, out_ff.row, out_ff.rho};
   assign rsp_tlast  = out_ff.last;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      sk_valid_ff |-> out_valid_ff)
      else $error("skid holds a word while output is empty");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(sk_valid_ff) |-> $past(out_valid_ff) && !$past(rsp_tready))
      else $error("skid filled without a stalled output");

   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      sk_valid_ff && !rsp_tready |=> sk_valid_ff)
      else $error("skid word dropped");

   a_last_diag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[39:32] == rsp_tdata[47:40])
      else $error("last word of frame not on the diagonal");

endmodule

`default_nettype wire

// ===== hdl/usad_lines.sv =====
`default_nettype none

module usad_lines (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        acc,
   input  logic                        frame_start,
   input  logic signed [usad_pkg::DW-1:0] rho_in,
   input  logic signed [usad_pkg::DW-1:0] u_in,
   input  logic signed [usad_pkg::DW-1:0] v_in,
   input  logic [usad_pkg::IW-1:0]     grid_last,
   output usad_pkg::usad_win_type      win
);
   import usad_pkg::*;

   logic [IW-1:0] row_ff, col_ff, row_in, col_in;
   logic [IW-1:0] r, c, c_nx;
   logic [IW:0]   c_p1;
   logic          emit, last_hit;

   // one bank per row parity
   logic signed [DW-1:0] bank0 [GRID_MAX];
   logic signed [DW-1:0] bank1 [GRID_MAX];
   logic signed [DW-1:0] u_line [GRID_MAX];
   logic signed [DW-1:0] v_line [GRID_MAX];

   logic signed [DW-1:0] b0a_ff, b0b_ff, b1a_ff, b1b_ff, u_ff, v_ff, rho_ff;
   logic                 acc_ff, emit_ff, last_ff, par_ff;
   logic [IW-1:0]        rowo_ff, colo_ff;

   always_comb begin
      r        = frame_start ? '0 : row_ff;
      c        = frame_start ? '0 : col_ff;
      c_p1     = {1'b0, c} + (IW+1)'(1);
      c_nx     = c_p1[IW-1:0];
      emit     = (r >= IW'(2)) && (r <= grid_last) && (c != '0)
                 && (c_p1 <= {1'b0, grid_last});
      last_hit = (r == grid_last) && (c_p1 == {1'b0, grid_last});
      if (c >= grid_last) begin
         col_in = '0;
         row_in = (r >= grid_last) ? '0 : r + IW'(1);
      end else begin
         col_in = c_nx;
         row_in = r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (acc) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= 1'b0;
         emit_ff <= 1'b0;
      end else if (en) begin
         acc_ff  <= acc;
         emit_ff <= acc && emit;
      end
   end

   // reads see the old contents of a column written in the same cycle
   always_ff @(posedge clock) begin
      if (en) begin
         b0a_ff  <= bank0[c];
         b0b_ff  <= bank0[c_nx];
         b1a_ff  <= bank1[c];
         b1b_ff  <= bank1[c_nx];
         u_ff    <= u_line[c];
         v_ff    <= v_line[c];
         rho_ff  <= rho_in;
         last_ff <= last_hit;
         rowo_ff <= r - IW'(1);
         colo_ff <= c;
         par_ff  <= r[0];
      end
      if (acc) begin
         if (r[0]) begin
            bank1[c] <= rho_in;
         end else begin
            bank0[c] <= rho_in;
         end
         u_line[c] <= u_in;
         v_line[c] <= v_in;
      end
   end

   always_comb begin
      win.acc   = acc_ff;
      win.emit  = emit_ff;
      win.last  = last_ff;
      win.row   = rowo_ff;
      win.col   = colo_ff;
      win.s_rho = rho_ff;
      win.n     = par_ff ? b1a_ff : b0a_ff;
      win.ctr   = par_ff ? b0a_ff : b1a_ff;
      win.e     = par_ff ? b0b_ff : b1b_ff;
      win.uu    = u_ff;
      win.vv    = v_ff;
   end

endmodule

`default_nettype wire

// ===== hdl/usad_calc.sv =====
`default_nettype none

module usad_calc (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  usad_pkg::usad_cfg_type cfg,
   input  usad_pkg::usad_win_type win,
   output usad_pkg::usad_res_type res,
   output logic                   res_valid
);
   import usad_pkg::*;

   localparam int DFW = DW + 1;        // first differences
   localparam int LPW = DW + 2;        // second differences
   localparam int KW  = CW + 1;        // coefficient as signed
   localparam int TW  = DW + KW;       // velocity times coefficient
   localparam int TRW = TW - 16;
   localparam int PW  = LPW + KW;      // diffusion product
   localparam int PRW = PW - 16;
   localparam int AW2 = TRW + DFW;     // advection product
   localparam int ARW = AW2 - 16;
   localparam int SPW = PRW + 2;       // center plus diffusion
   localparam int SW  = ARW + 2;

   localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

   logic         vld_ff [2:7];
   usad_tag_type tag_ff [2:7];

   logic signed [DW-1:0] ctr_hold_ff;

   // stage 2
   logic signed [DFW-1:0] dxd_in, dyd_in;
   logic signed [LPW-1:0] lapx_in, lapy_in;
   logic signed [DW-1:0]  s2_ctr_ff, s2_uu_ff, s2_vv_ff;
   logic signed [DFW-1:0] s2_dxd_ff, s2_dyd_ff;
   logic signed [LPW-1:0] s2_lapx_ff, s2_lapy_ff;

   // stage 3
   logic signed [KW-1:0]  kax, kay, kdx, kdy;
   logic signed [TW-1:0]  s3_tx_ff, s3_ty_ff;
   logic signed [PW-1:0]  s3_px_ff, s3_py_ff;
   logic signed [DFW-1:0] s3_dxd_ff, s3_dyd_ff;
   logic signed [DW-1:0]  s3_ctr_ff;

   // stage 4
   logic signed [TW-1:0]  tx_sum, ty_sum;
   logic signed [PW-1:0]  px_sum, py_sum;
   logic signed [TRW-1:0] s4_tx_ff, s4_ty_ff;
   logic signed [PRW-1:0] s4_px_ff, s4_py_ff;
   logic signed [DFW-1:0] s4_dxd_ff, s4_dyd_ff;
   logic signed [DW-1:0]  s4_ctr_ff;

   // stage 5
   logic signed [AW2-1:0] s5_ax_ff, s5_ay_ff;
   logic signed [SPW-1:0] s5_part_ff;

   // stage 6
   logic signed [AW2-1:0] ax_sum, ay_sum;
   logic signed [ARW-1:0] s6_ax_ff, s6_ay_ff;
   logic signed [SPW-1:0] s6_part_ff;

   // stage 7
   logic signed [SW-1:0]  total;
   logic signed [DW-1:0]  sat_in;
   logic signed [DW-1:0]  s7_rho_ff;

   always_comb begin
      dxd_in  = (win.uu >= 0) ? DFW'(win.ctr) - DFW'(win.n)
                              : DFW'(win.s_rho) - DFW'(win.ctr);
      dyd_in  = (win.vv >= 0) ? DFW'(win.ctr) - DFW'(ctr_hold_ff)
                              : DFW'(win.e) - DFW'(win.ctr);
      lapx_in = LPW'(win.n) - (LPW'(win.ctr) <<< 1) + LPW'(win.s_rho);
      lapy_in = LPW'(ctr_hold_ff) - (LPW'(win.ctr) <<< 1) + LPW'(win.e);

      kax = $signed({1'b0, cfg.adv_x});
      kay = $signed({1'b0, cfg.adv_y});
      kdx = $signed({1'b0, cfg.diff_x});
      kdy = $signed({1'b0, cfg.diff_y});

      // add half, then floor shift
      tx_sum = s3_tx_ff + TW'(32768);
      ty_sum = s3_ty_ff + TW'(32768);
      px_sum = s3_px_ff + PW'(32768);
      py_sum = s3_py_ff + PW'(32768);
      ax_sum = s5_ax_ff + AW2'(32768);
      ay_sum = s5_ay_ff + AW2'(32768);

      total = SW'(s6_part_ff) - SW'(s6_ax_ff) - SW'(s6_ay_ff);
      if (total > SW'(SAT_MAX)) begin
         sat_in = SAT_MAX;
      end else if (total < SW'(SAT_MIN)) begin
         sat_in = SAT_MIN;
      end else begin
         sat_in = total[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 2; i <= 7; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[2] <= win.emit;
         for (int i = 3; i <= 7; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (win.acc) begin
            ctr_hold_ff <= win.ctr;
         end

         tag_ff[2] <= '{row: win.row, col: win.col, last: win.last};
         for (int i = 3; i <= 7; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end

         s2_ctr_ff  <= win.ctr;
         s2_uu_ff   <= win.uu;
         s2_vv_ff   <= win.vv;
         s2_dxd_ff  <= dxd_in;
         s2_dyd_ff  <= dyd_in;
         s2_lapx_ff <= lapx_in;
         s2_lapy_ff <= lapy_in;

         s3_tx_ff  <= s2_uu_ff * kax;
         s3_ty_ff  <= s2_vv_ff * kay;
         s3_px_ff  <= s2_lapx_ff * kdx;
         s3_py_ff  <= s2_lapy_ff * kdy;
         s3_dxd_ff <= s2_dxd_ff;
         s3_dyd_ff <= s2_dyd_ff;
         s3_ctr_ff <= s2_ctr_ff;

         s4_tx_ff  <= tx_sum[TW-1:16];
         s4_ty_ff  <= ty_sum[TW-1:16];
         s4_px_ff  <= px_sum[PW-1:16];
         s4_py_ff  <= py_sum[PW-1:16];
         s4_dxd_ff <= s3_dxd_ff;
         s4_dyd_ff <= s3_dyd_ff;
         s4_ctr_ff <= s3_ctr_ff;

         s5_ax_ff   <= s4_tx_ff * s4_dxd_ff;
         s5_ay_ff   <= s4_ty_ff * s4_dyd_ff;
         s5_part_ff <= SPW'(s4_ctr_ff) + SPW'(s4_px_ff) + SPW'(s4_py_ff);

         s6_ax_ff   <= ax_sum[AW2-1:16];
         s6_ay_ff   <= ay_sum[AW2-1:16];
         s6_part_ff <= s5_part_ff;

         s7_rho_ff <= sat_in;
      end
   end

   always_comb begin
      res.rho   = s7_rho_ff;
      res.row   = tag_ff[7].row;
      res.col   = tag_ff[7].col;
      res.last  = tag_ff[7].last;
      res_valid = vld_ff[7];
   end

endmodule

`default_nettype wire
